// ----- rtl/media_pdu_deframer_assert.svh -----
// assertion macros for the deframer rtl, included by mpd_queue
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef MEDIA_PDU_DEFRAMER_ASSERT_SVH
`define MEDIA_PDU_DEFRAMER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MPD_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define MPD_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mpd_pkg.sv -----
`timescale 1ns / 1ps
// types and constants of the media pdu deframer
// no dependencies
package mpd_pkg;

    localparam int TIME_BYTES  = 8;
    localparam int TIME_W      = 8 * TIME_BYTES;
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // header byte positions, big-endian fields in stream order
    localparam logic [5:0] POS_TYPE       = 6'd4;
    localparam logic [5:0] POS_OFFSET_END = 6'd8;
    localparam logic [5:0] POS_SIZE_END   = 6'd12;
    localparam logic [5:0] POS_TIME_END   = 6'(12 + TIME_BYTES);
    localparam logic [5:0] POS_FLAGS_END  = 6'(16 + TIME_BYTES);
    localparam logic [5:0] POS_RES_END    = 6'(20 + TIME_BYTES);
    localparam logic [5:0] POS_LEN_END    = 6'(24 + TIME_BYTES);

    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_BODY      = 2'd1;
    localparam logic [1:0] KIND_BAD_START = 2'd2;
    localparam logic [1:0] KIND_BAD_LEN   = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         unit_type;
        logic [31:0]        payload_offset;
        logic [31:0]        payload_size;
        logic signed [63:0] timestamp_us;
        logic [31:0]        flag_word;
        logic [31:0]        reserved_word;
        logic [30:0]        body_length;
        logic [7:0]         body_byte;
        logic               last;
    } t_result;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

// ----- rtl/mpd_ifs.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for the byte input and the result output
// standalone, no package needed
interface mpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mpd_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         unit_type;
    logic [31:0]        payload_offset;
    logic [31:0]        payload_size;
    logic signed [63:0] timestamp_us;
    logic [31:0]        flag_word;
    logic [31:0]        reserved_word;
    logic [30:0]        body_length;
    logic [7:0]         body_byte;
    logic               last;

    modport source (output valid, output kind, output unit_type, output payload_offset,
                    output payload_size, output timestamp_us, output flag_word,
                    output reserved_word, output body_length, output body_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input unit_type, input payload_offset,
                    input payload_size, input timestamp_us, input flag_word,
                    input reserved_word, input body_length, input body_byte,
                    input last, output ready);
endinterface

// ----- rtl/mpd_front.sv -----
`timescale 1ns / 1ps
// front end: accepts stream bytes, collects the header, classifies each byte
// depends on mpd_pkg and mpd_byte_if
module mpd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    mpd_byte_if.sink           i_byte,
    input  mpd_pkg::t_q_status i_q_status,
    output logic               o_push,
    output mpd_pkg::t_result   o_push_data
);
    import mpd_pkg::*;

    logic [31:0]       r_start;
    logic              r_in_body,   n_in_body;
    logic [5:0]        r_count,     n_count;
    logic [30:0]       r_body_left, n_body_left;
    logic [31:0]       r_marker,    n_marker;
    logic [7:0]        r_type,      n_type;
    logic [31:0]       r_offset,    n_offset;
    logic [31:0]       r_size,      n_size;
    logic [TIME_W-1:0] r_time,      n_time;
    logic [31:0]       r_flags,     n_flags;
    logic [31:0]       r_reserved,  n_reserved;
    logic [31:0]       r_length,    n_length;
    logic              accept;
    logic [7:0]        b;
    t_result           res;

    assign i_byte.ready = !i_q_status.full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;

    always_comb begin
        n_in_body   = r_in_body;
        n_count     = r_count;
        n_body_left = r_body_left;
        n_marker    = r_marker;
        n_type      = r_type;
        n_offset    = r_offset;
        n_size      = r_size;
        n_time      = r_time;
        n_flags     = r_flags;
        n_reserved  = r_reserved;
        n_length    = r_length;
        res         = '0;
        o_push      = 1'b0;
        if (accept) begin
            if (r_in_body) begin
                res.kind      = KIND_BODY;
                res.body_byte = b;
                res.last      = (r_body_left == 31'd1);
                n_body_left   = r_body_left - 31'd1;
                if (n_body_left == 31'd0) begin
                    n_in_body = 1'b0;
                end
                o_push = 1'b1;
            end else begin
                n_count = r_count + 6'd1;
                if (r_count < POS_TYPE) begin
                    n_marker = {r_marker[23:0], b};
                    if (r_count == POS_TYPE - 6'd1 && n_marker != r_start) begin
                        n_count  = 6'd0;
                        res.kind = KIND_BAD_START;
                        res.last = 1'b1;
                        o_push   = 1'b1;
                    end
                end else if (r_count == POS_TYPE) begin
                    n_type = b;
                end else if (r_count <= POS_OFFSET_END) begin
                    n_offset = {r_offset[23:0], b};
                end else if (r_count <= POS_SIZE_END) begin
                    n_size = {r_size[23:0], b};
                end else if (r_count <= POS_TIME_END) begin
                    n_time = {r_time[TIME_W-9:0], b};
                end else if (r_count <= POS_FLAGS_END) begin
                    n_flags = {r_flags[23:0], b};
                end else if (r_count <= POS_RES_END) begin
                    n_reserved = {r_reserved[23:0], b};
                end else begin
                    n_length = {r_length[23:0], b};
                    if (r_count == POS_LEN_END) begin
                        // whole header in hand: decide the unit
                        n_count            = 6'd0;
                        res.unit_type      = r_type;
                        res.payload_offset = r_offset;
                        res.payload_size   = r_size;
                        res.timestamp_us   = 64'($signed(r_time));
                        res.flag_word      = r_flags;
                        res.reserved_word  = r_reserved;
                        res.body_length    = n_length[30:0];
                        o_push             = 1'b1;
                        if (n_length[31]) begin
                            res.kind = KIND_BAD_LEN;
                            res.last = 1'b1;
                        end else begin
                            res.kind    = KIND_HEADER;
                            n_body_left = n_length[30:0];
                            res.last    = (n_length[30:0] == 31'd0);
                            n_in_body   = (n_length[30:0] != 31'd0);
                        end
                    end
                end
            end
        end
    end

    assign o_push_data = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= 32'd0;
            r_in_body   <= 1'b0;
            r_count     <= 6'd0;
            r_body_left <= 31'd0;
        end else begin
            if (i_cfg_we) begin
                r_start <= i_cfg_data;
            end
            r_in_body   <= n_in_body;
            r_count     <= n_count;
            r_body_left <= n_body_left;
        end
    end

    // header field registers are fully rewritten before each use
    always_ff @(posedge i_clk) begin
        r_marker   <= n_marker;
        r_type     <= n_type;
        r_offset   <= n_offset;
        r_size     <= n_size;
        r_time     <= n_time;
        r_flags    <= n_flags;
        r_reserved <= n_reserved;
        r_length   <= n_length;
    end

endmodule

// ----- rtl/mpd_queue.sv -----
`timescale 1ns / 1ps
// short shifting queue of classified results between front and back
// depends on mpd_pkg and media_pdu_deframer_assert.svh
module mpd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mpd_pkg::t_result   i_push_data,
    input  logic               i_pop,
    output mpd_pkg::t_result   o_head,
    output mpd_pkg::t_q_status o_status
);
    import mpd_pkg::*;

    t_result           r_entry [QUEUE_DEPTH];
    logic [QCNT_W-1:0] r_count, n_count;
    logic [QIDX_W-1:0] wr_idx;

    // head always sits in entry zero
    assign o_head             = r_entry[0];
    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == QCNT_W'(QUEUE_DEPTH));

    assign wr_idx  = QIDX_W'(r_count - QCNT_W'(i_pop));
    assign n_count = r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // each entry takes either the incoming result or its neighbor, never both
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (i_push && wr_idx == QIDX_W'(i)) begin
                r_entry[i] <= i_push_data;
            end else if (i_pop) begin
                r_entry[i] <= r_entry[i + 1];
            end
        end
        if (i_push && wr_idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
            r_entry[QUEUE_DEPTH - 1] <= i_push_data;
        end
    end

`include "media_pdu_deframer_assert.svh"

    `MPD_AST_IMP(a_no_push_full, i_push, !o_status.full, "push into full queue")
    `MPD_AST_IMP(a_no_pop_empty, i_pop, o_status.not_empty, "pop from empty queue")
    `MPD_AST_IMP(a_cnt_bound, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `MPD_AST_NXT(a_cnt_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count not up")

endmodule

// ----- rtl/mpd_back.sv -----
`timescale 1ns / 1ps
// back end: output register that presents queued results on the result channel
// depends on mpd_pkg and mpd_result_if
module mpd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpd_pkg::t_result   i_head,
    input  mpd_pkg::t_q_status i_q_status,
    output logic               o_pop,
    mpd_result_if.source       o_result
);
    import mpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // refill when the register is empty or its transaction completes now
    assign o_pop = i_q_status.not_empty && (!r_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.kind           = r_res.kind;
    assign o_result.unit_type      = r_res.unit_type;
    assign o_result.payload_offset = r_res.payload_offset;
    assign o_result.payload_size   = r_res.payload_size;
    assign o_result.timestamp_us   = r_res.timestamp_us;
    assign o_result.flag_word      = r_res.flag_word;
    assign o_result.reserved_word  = r_res.reserved_word;
    assign o_result.body_length    = r_res.body_length;
    assign o_result.body_byte      = r_res.body_byte;
    assign o_result.last           = r_res.last;

endmodule

// ----- rtl/media_pdu_deframer.sv -----
`timescale 1ns / 1ps
// channel    dir  payload
// i_byte     in   data_byte (8)
// o_result   out  kind, header fields, body_length, body_byte, last
// i_cfg_*    in   start_word (32), written when i_cfg_we is high
//
// one byte per cycle while the queue has room; each byte is classified in the cycle it is taken
// a result reaches o_result through a queue entry and then the output register
// a two-entry queue feeds the output register, so input stalls only after it fills
// synchronous reset clears the start word, body flag, byte and body counts, queue count, r_valid
// depends on mpd_pkg, mpd_ifs, mpd_front, mpd_queue, mpd_back
module media_pdu_deframer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data,
    mpd_byte_if.sink      i_byte,
    mpd_result_if.source  o_result
);
    import mpd_pkg::*;

    logic      push;
    logic      pop;
    t_result   push_data;
    t_result   head;
    t_q_status q_status;

    mpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (i_byte),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    mpd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    mpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_result   (o_result)
    );

endmodule
